@@ rtl/cthsv_pkg.sv @@
// Shared constants and types for the RGB color tween through HSV.
package cthsv_pkg;

  // Tween amount: 9 bits, 256 is full scale
  localparam int unsigned MIX_BITS = 9;
  localparam logic [MIX_BITS-1:0] MIX_ONE = 9'd256;

  // Hue base of the sextant that holds the largest channel
  typedef enum logic [2:0] {
    SEXT_RED   = 3'd0,
    SEXT_GREEN = 3'd2,
    SEXT_BLUE  = 3'd4,
    SEXT_WRAP  = 3'd6
  } hue_sext_e;

  // Tween controls that ride alongside the color conversion
  typedef struct packed {
    logic [MIX_BITS-1:0] frac;
    logic                backward;
  } mix_ctrl_t;

endpackage

@@ rtl/cthsv_in_if.sv @@
// Input channel: two RGB colors, tween amount and hue direction.
interface cthsv_in_if
  import cthsv_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_a;
  logic [CHANNEL_BITS-1:0] green_a;
  logic [CHANNEL_BITS-1:0] blue_a;
  logic [CHANNEL_BITS-1:0] red_b;
  logic [CHANNEL_BITS-1:0] green_b;
  logic [CHANNEL_BITS-1:0] blue_b;
  logic [MIX_BITS-1:0]     mix_fraction;
  logic                    hue_backward;

  modport source (
    output valid, red_a, green_a, blue_a, red_b, green_b, blue_b,
           mix_fraction, hue_backward,
    input  ready
  );
  modport sink (
    input  valid, red_a, green_a, blue_a, red_b, green_b, blue_b,
           mix_fraction, hue_backward,
    output ready
  );
endinterface

@@ rtl/cthsv_out_if.sv @@
// Output channel: one interpolated RGB color.
interface cthsv_out_if #(
  parameter int unsigned CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_out;
  logic [CHANNEL_BITS-1:0] green_out;
  logic [CHANNEL_BITS-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

@@ rtl/cthsv_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, round to nearest.
module cthsv_div #(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [CHANNEL_BITS-1:0]  num_i,
  input  logic [CHANNEL_BITS-1:0]  dvs_i,
  output logic [FRACTION_BITS:0]   quo_o
);
  localparam int unsigned QW = FRACTION_BITS + 1;
  localparam int unsigned NW = CHANNEL_BITS + FRACTION_BITS + 2;
  localparam int unsigned DW = CHANNEL_BITS + 1;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] dvs_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] dvs_in;
    logic [QW-1:0] quo_in;
    logic [NW-1:0] trial;
    logic          ge;

    // Numerator 2*n*ONE + d over divisor 2*d gives the rounded quotient
    if (j == 0) begin : g_first
      assign rem_in = NW'({num_i, {(FRACTION_BITS + 1){1'b0}}}) + NW'(dvs_i);
      assign dvs_in = {dvs_i, 1'b0};
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign dvs_in = dvs_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    // Try the shifted divisor for this bit
    assign trial = NW'(dvs_in) << (QW - 1 - j);
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? (rem_in - trial) : rem_in;
        dvs_q[j] <= dvs_in;
        quo_q[j] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QW-1];
endmodule

@@ rtl/cthsv_to_hsv.sv @@
// RGB to hexcone HSV conversion pipeline for one color.
module cthsv_to_hsv
  import cthsv_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [CHANNEL_BITS-1:0]    red_i,
  input  logic [CHANNEL_BITS-1:0]    green_i,
  input  logic [CHANNEL_BITS-1:0]    blue_i,
  output logic                       vld_o,
  output logic [FRACTION_BITS+2:0]   hue_o,
  output logic [FRACTION_BITS:0]     sat_o,
  output logic [FRACTION_BITS:0]     val_o
);
  localparam int unsigned QW  = FRACTION_BITS + 1;
  localparam int unsigned HW  = FRACTION_BITS + 3;
  localparam int unsigned LAT = QW + 2;
  localparam int unsigned MW  = 6;
  localparam int unsigned ZW  = CHANNEL_BITS + FRACTION_BITS;
  localparam int unsigned RS  = ZW + CHANNEL_BITS;
  localparam int unsigned RW  = ZW + 1;
  localparam longint unsigned CMAX_L = (64'd1 << CHANNEL_BITS) - 64'd1;
  // Reciprocal of full scale, rounded up, exact for every numerator below 2^ZW
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RS) + CMAX_L - 64'd1) / CMAX_L);
  localparam logic [ZW-1:0] VAL_BIAS = ZW'((64'd1 << (CHANNEL_BITS - 1)) - 64'd1);
  localparam logic [QW-1:0] ONE = QW'(1) << FRACTION_BITS;
  localparam logic [HW-1:0] HUE_SPAN = HW'(6) << FRACTION_BITS;

  logic [CHANNEL_BITS-1:0] mx, mn, diff;
  hue_sext_e               sext;
  logic                    neg;

  logic [CHANNEL_BITS-1:0] mx_q, d_q, diff_q;
  hue_sext_e               sext_q;
  logic                    neg_q;
  logic [MW-1:0]           meta_q [QW];
  logic [CHANNEL_BITS-1:0] mx_dly_q [QW];
  logic [LAT-1:0]          vld_q;

  logic [QW-1:0]           quo_s, quo_h;
  logic [CHANNEL_BITS-1:0] dvs_s, dvs_h;
  logic [MW-1:0]           meta;
  logic [HW-1:0]           base, hue_raw, hue_d;
  logic [HW-1:0]           hue_q;
  logic [QW-1:0]           sat_q, val_q;
  logic [ZW-1:0]           val_num;
  logic [ZW+RW-1:0]        val_prod;
  logic [QW-1:0]           val_d;

  // Find max, min and the sextant of the color
  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    if (red_i >= green_i && red_i >= blue_i) begin
      if (green_i >= blue_i) begin
        sext = SEXT_RED;  neg = 1'b0; diff = green_i - blue_i;
      end else begin
        sext = SEXT_WRAP; neg = 1'b1; diff = blue_i - green_i;
      end
    end else if (green_i >= blue_i) begin
      if (blue_i >= red_i) begin
        sext = SEXT_GREEN; neg = 1'b0; diff = blue_i - red_i;
      end else begin
        sext = SEXT_GREEN; neg = 1'b1; diff = red_i - blue_i;
      end
    end else begin
      if (red_i >= green_i) begin
        sext = SEXT_BLUE; neg = 1'b0; diff = red_i - green_i;
      end else begin
        sext = SEXT_BLUE; neg = 1'b1; diff = green_i - red_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q   <= mx;
      d_q    <= mx - mn;
      diff_q <= diff;
      sext_q <= sext;
      neg_q  <= neg;
    end
  end

  // Substitute a divisor of one where the quotient is dropped anyway
  assign dvs_s = (mx_q == '0) ? CHANNEL_BITS'(1) : mx_q;
  assign dvs_h = (d_q == '0)  ? CHANNEL_BITS'(1) : d_q;

  cthsv_div #(.CHANNEL_BITS(CHANNEL_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div_sat (
    .clk_i, .en_i, .num_i(d_q), .dvs_i(dvs_s), .quo_o(quo_s)
  );
  cthsv_div #(.CHANNEL_BITS(CHANNEL_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div_hue (
    .clk_i, .en_i, .num_i(diff_q), .dvs_i(dvs_h), .quo_o(quo_h)
  );

  // Carry sextant, sign, black and grey flags and the max alongside the dividers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0]   <= {sext_q, neg_q, (mx_q == '0), (d_q == '0)};
      mx_dly_q[0] <= mx_q;
      for (int i = 1; i < QW; i++) begin
        meta_q[i]   <= meta_q[i-1];
        mx_dly_q[i] <= mx_dly_q[i-1];
      end
    end
  end
  assign meta = meta_q[QW-1];

  // Value: round(max * ONE / full scale) by reciprocal multiplication
  assign val_num  = ZW'({mx_dly_q[QW-1], {FRACTION_BITS{1'b0}}}) + VAL_BIAS;
  assign val_prod = (ZW+RW)'(val_num) * (ZW+RW)'(RECIP);
  assign val_d    = val_prod[RS +: QW];

  // Assemble hue with wrap and zero it for grey, force black to full saturation
  always_comb begin
    base    = HW'(meta[5:3]) << FRACTION_BITS;
    hue_raw = meta[2] ? (base - HW'(quo_h)) : (base + HW'(quo_h));
    hue_d   = (hue_raw >= HUE_SPAN) ? (hue_raw - HUE_SPAN) : hue_raw;
    if (meta[0]) hue_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q <= hue_d;
      sat_q <= meta[1] ? ONE : quo_s;
      val_q <= val_d;
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], vld_i};
    end
  end

  assign vld_o = vld_q[LAT-1];
  assign hue_o = hue_q;
  assign sat_o = sat_q;
  assign val_o = val_q;

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> hue_o < HUE_SPAN) else $error("hue out of range");
  a_sv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> (sat_o <= ONE && val_o <= ONE)) else $error("sat or value above one");
  a_black_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_o && val_o == '0) |-> sat_o == ONE) else $error("black not fully saturated");
endmodule

@@ rtl/cthsv_hsv2rgb.sv @@
// HSV tween and conversion back to RGB, four register stages.
module cthsv_hsv2rgb
  import cthsv_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  mix_ctrl_t                  mix_i,
  input  logic [FRACTION_BITS+2:0]   hue_a_i,
  input  logic [FRACTION_BITS:0]     sat_a_i,
  input  logic [FRACTION_BITS:0]     val_a_i,
  input  logic [FRACTION_BITS+2:0]   hue_b_i,
  input  logic [FRACTION_BITS:0]     sat_b_i,
  input  logic [FRACTION_BITS:0]     val_b_i,
  output logic                       vld_o,
  output logic [CHANNEL_BITS-1:0]    red_o,
  output logic [CHANNEL_BITS-1:0]    green_o,
  output logic [CHANNEL_BITS-1:0]    blue_o
);
  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned QW  = F + 1;
  localparam int unsigned HW  = F + 3;
  localparam int unsigned AW  = HW + MIX_BITS + 1;
  localparam int unsigned PW  = 2 * F + 1;
  localparam int unsigned XW  = PW + CHANNEL_BITS + 1;
  localparam logic [QW-1:0] ONE  = QW'(1) << F;
  localparam logic [QW-1:0] HALF = QW'(1) << (F - 1);
  localparam logic [HW-1:0] HUE_SPAN = HW'(6) << F;
  localparam logic [XW-1:0] CH_HALF = XW'(1) << (2 * F - 1);

  function automatic logic [HW-1:0] blend(logic [HW-1:0] a, logic [HW-1:0] b,
                                          logic [MIX_BITS-1:0] t);
    logic [AW-1:0] acc;
    acc = AW'(a) * AW'(MIX_ONE - t) + AW'(b) * AW'(t) + AW'(128);
    return HW'(acc >> 8);
  endfunction

  function automatic logic [HW-1:0] hue_step(logic [HW-1:0] gap, logic [MIX_BITS-1:0] t);
    logic [AW-1:0] acc;
    acc = AW'(t) * AW'(HUE_SPAN - gap) + AW'(128);
    return HW'(acc >> 8);
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] to_channel(logic [PW-1:0] x);
    logic [XW-1:0] acc;
    acc = (XW'(x) << CHANNEL_BITS) - XW'(x) + CH_HALF;
    return acc[2*F +: CHANNEL_BITS];
  endfunction

  logic [3:0]          vld_q;
  logic [HW-1:0]       step, hue_d, h_q;
  logic [HW:0]         hsum;
  logic [QW-1:0]       s1_q, v1_q;
  logic [2:0]          k2_q;
  logic [QW-1:0]       v2_q, s2_q, sf2_q, sg2_q;
  logic [F-1:0]        f;
  logic [2*QW-1:0]     prod_f, prod_g;
  logic [PW-1:0]       vv, pp, qq, ww;
  logic [PW-1:0]       ro_d, go_d, bo_d, ro_q, go_q, bo_q;
  logic [CHANNEL_BITS-1:0] red_q, green_q, blue_q;

  // Tween hue around the wheel in the chosen direction
  always_comb begin
    step  = '0;
    hsum  = '0;
    if (!mix_i.backward) begin
      if (hue_b_i >= hue_a_i) begin
        hue_d = blend(hue_a_i, hue_b_i, mix_i.frac);
      end else begin
        step  = hue_step(hue_a_i - hue_b_i, mix_i.frac);
        hsum  = (HW+1)'(hue_a_i) + (HW+1)'(step);
        hue_d = (hsum >= (HW+1)'(HUE_SPAN)) ? HW'(hsum - (HW+1)'(HUE_SPAN)) : HW'(hsum);
      end
    end else begin
      if (hue_a_i >= hue_b_i) begin
        hue_d = blend(hue_a_i, hue_b_i, mix_i.frac);
      end else begin
        step  = hue_step(hue_b_i - hue_a_i, mix_i.frac);
        hue_d = (step > hue_a_i) ? (hue_a_i + HUE_SPAN - step) : (hue_a_i - step);
      end
    end
    if (hue_d >= HUE_SPAN) hue_d = '0;
  end

  // Stage 1: blended hue, saturation and value
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q  <= hue_d;
      s1_q <= QW'(blend(HW'(sat_a_i), HW'(sat_b_i), mix_i.frac));
      v1_q <= QW'(blend(HW'(val_a_i), HW'(val_b_i), mix_i.frac));
    end
  end

  // Stage 2: sextant and saturation-scaled fractions
  assign f      = h_q[F-1:0];
  assign prod_f = (2*QW)'(s1_q) * (2*QW)'(f) + (2*QW)'(HALF);
  assign prod_g = (2*QW)'(s1_q) * (2*QW)'(ONE - QW'(f)) + (2*QW)'(HALF);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k2_q  <= h_q[F +: 3];
      v2_q  <= v1_q;
      s2_q  <= s1_q;
      sf2_q <= QW'(prod_f >> F);
      sg2_q <= QW'(prod_g >> F);
    end
  end

  // Stage 3: sextant products and channel selection
  always_comb begin
    vv = PW'(v2_q) << F;
    pp = PW'((2*QW)'(v2_q) * (2*QW)'(ONE - s2_q));
    qq = PW'((2*QW)'(v2_q) * (2*QW)'(ONE - sf2_q));
    ww = PW'((2*QW)'(v2_q) * (2*QW)'(ONE - sg2_q));
    unique case (k2_q)
      3'd0:    begin ro_d = vv; go_d = ww; bo_d = pp; end
      3'd1:    begin ro_d = qq; go_d = vv; bo_d = pp; end
      3'd2:    begin ro_d = pp; go_d = vv; bo_d = ww; end
      3'd3:    begin ro_d = pp; go_d = qq; bo_d = vv; end
      3'd4:    begin ro_d = ww; go_d = pp; bo_d = vv; end
      default: begin ro_d = vv; go_d = pp; bo_d = qq; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ro_q <= ro_d;
      go_q <= go_d;
      bo_q <= bo_d;
    end
  end

  // Stage 4: scale to channel range, output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= to_channel(ro_q);
      green_q <= to_channel(go_q);
      blue_q  <= to_channel(bo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  assign vld_o   = vld_q[3];
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  a_blend_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> h_q < HUE_SPAN) else $error("blended hue out of range");
  a_blend_sv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (s1_q <= ONE && v1_q <= ONE)) else $error("blended sat or value above one");
  a_sext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> k2_q < 3'd6) else $error("sextant out of range");
endmodule

@@ rtl/rgb_color_tween_via_hsv.sv @@
// Top level: RGB color tween through hexcone HSV, fully pipelined.
// The pipeline depth from input to output item is set by the bit-per-stage dividers.
// Throughput: one item per cycle while no finished item waits at a held output.
// All stages advance together while the output register is empty or drained.
// Reset clears every valid bit; data registers hold stale values until refilled.
module rgb_color_tween_via_hsv
  import cthsv_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cthsv_in_if.sink    in_i,
  cthsv_out_if.source out_o
);
  localparam int unsigned HSV_LAT = FRACTION_BITS + 3;

  logic      adv;
  logic      vld_a, vld_b;
  mix_ctrl_t mix_in;
  mix_ctrl_t mix_q [HSV_LAT];
  logic [FRACTION_BITS+2:0] hue_a, hue_b;
  logic [FRACTION_BITS:0]   sat_a, sat_b, val_a, val_b;

  // Advance the whole pipeline unless a finished item waits
  assign adv        = out_o.ready | ~out_o.valid;
  assign in_i.ready = adv;

  // Saturate tween amount at full scale
  assign mix_in.frac     = (in_i.mix_fraction > MIX_ONE) ? MIX_ONE : in_i.mix_fraction;
  assign mix_in.backward = in_i.hue_backward;

  cthsv_to_hsv #(.CHANNEL_BITS(CHANNEL_BITS), .FRACTION_BITS(FRACTION_BITS)) u_hsv_a (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(in_i.valid),
    .red_i(in_i.red_a), .green_i(in_i.green_a), .blue_i(in_i.blue_a),
    .vld_o(vld_a), .hue_o(hue_a), .sat_o(sat_a), .val_o(val_a)
  );
  cthsv_to_hsv #(.CHANNEL_BITS(CHANNEL_BITS), .FRACTION_BITS(FRACTION_BITS)) u_hsv_b (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(in_i.valid),
    .red_i(in_i.red_b), .green_i(in_i.green_b), .blue_i(in_i.blue_b),
    .vld_o(vld_b), .hue_o(hue_b), .sat_o(sat_b), .val_o(val_b)
  );

  // Delay tween controls to meet the converted colors
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mix_q[0] <= mix_in;
      for (int i = 1; i < HSV_LAT; i++) mix_q[i] <= mix_q[i-1];
    end
  end

  cthsv_hsv2rgb #(.CHANNEL_BITS(CHANNEL_BITS), .FRACTION_BITS(FRACTION_BITS)) u_rgb (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(vld_a), .mix_i(mix_q[HSV_LAT-1]),
    .hue_a_i(hue_a), .sat_a_i(sat_a), .val_a_i(val_a),
    .hue_b_i(hue_b), .sat_b_i(sat_b), .val_b_i(val_b),
    .vld_o(out_o.valid), .red_o(out_o.red_out), .green_o(out_o.green_out),
    .blue_o(out_o.blue_out)
  );

  a_lanes_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_a == vld_b) else $error("color lanes out of step");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid) else $error("stall without a waiting item");
  a_rise_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(adv)) else $error("output appeared while held");
endmodule
